// ----- hdl/kuramoto_mean_field_step_top_defines.svh -----
// Assertion macros for the oscillator swarm step block.
// No dependencies; included by files that carry concurrent checks.
`ifndef KURAMOTO_MEAN_FIELD_STEP_TOP_DEFINES_SVH
`define KURAMOTO_MEAN_FIELD_STEP_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define KMF_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("kmf assertion failed");
`define KMF_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("kmf forbidden condition");
`else
`define KMF_ASSERT(lbl, prop)
`define KMF_NEVER(lbl, cond)
`endif
`endif

// ----- hdl/kmf_pkg.sv -----
// Shared constants, tables, types and helpers for the oscillator swarm step.
// No dependencies.
package kmf_pkg;

  localparam int MAX_OSC_DEF    = 256;
  localparam int PHASE_BITS_DEF = 16;
  localparam int CORDIC_ITERS   = 16;
  localparam int CFG_IDX_W      = 1;
  localparam int CFG_DATA_W     = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_COUNT  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_COH_THRESHOLD = CFG_IDX_W'(1);

  localparam logic [8:0]  ACTIVE_COUNT_RST = 9'd200;
  localparam logic [15:0] COH_THRESH_RST   = 16'd11469;
  localparam logic [31:0] LAST_SEED_RST    = 32'hFFFF_FFFF;

  localparam logic [31:0] CORDIC_GAIN_INV = 32'd652032874;
  localparam logic [31:0] INV_TWO_PI_Q32  = 32'd683565276;
  localparam logic [31:0] SCATTER_STEP    = 32'd273426;
  localparam logic [15:0] Q15_ONE         = 16'd32768;

  // arctan(2^-i) in 2^-32 turn
  localparam logic [31:0] ATAN_TURN [CORDIC_ITERS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
  };

  typedef enum logic [0:0] {CM_ROTATE, CM_VECTOR} kmf_cordic_mode_t;

  typedef enum logic [1:0] {CS_IDLE, CS_ITER, CS_FIN} kmf_cordic_state_t;

  typedef enum logic [4:0] {
    S_IDLE, S_SC_RD, S_SC_WR, S_SUM_RD, S_SUM_ST, S_SUM_WT,
    S_DIV_X, S_DIV_XW, S_DIV_Y, S_DIV_YW, S_SQ_X, S_SQ_Y,
    S_SQRT, S_SQRT_W, S_ATAN, S_ATAN_W, S_KR,
    S_UP_RD, S_UP_ST, S_UP_WT, S_UP_M2, S_UP_WR, S_DONE
  } kmf_state_t;

  typedef struct packed {
    logic             start;
    kmf_cordic_mode_t mode;
    logic [31:0]      angle;
    logic signed [16:0] vx;
    logic signed [16:0] vy;
  } kmf_cordic_req_t;

  typedef struct packed {
    logic               done;
    logic signed [16:0] cos_v;
    logic signed [16:0] sin_v;
    logic [31:0]        z;
  } kmf_cordic_rsp_t;

  function automatic logic [31:0] xorshift32(input logic [31:0] q);
    logic [31:0] t;
    t = q ^ (q << 13);
    t = t ^ (t >> 17);
    t = t ^ (t << 5);
    return t;
  endfunction

endpackage

// ----- hdl/kmf_if.sv -----
// Valid/ready channel interfaces for swarm items and results.
// No dependencies.
interface kmf_in_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic [7:0]         osc_index;
  logic [15:0]        init_phase;
  logic signed [15:0] natural_freq;
  logic [15:0]        coupling;
  logic [31:0]        seed;
  modport source (output valid, kind, osc_index, init_phase, natural_freq, coupling, seed,
                  input ready);
  modport sink (input valid, kind, osc_index, init_phase, natural_freq, coupling, seed,
                output ready);
endinterface

interface kmf_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] order_magnitude;
  logic [15:0] mean_phase;
  logic        coherent;
  modport source (output valid, order_magnitude, mean_phase, coherent, input ready);
  modport sink (input valid, order_magnitude, mean_phase, coherent, output ready);
endinterface

// ----- hdl/kmf_cordic.sv -----
// Iterative CORDIC, one micro-rotation per cycle: rotation for sin/cos,
// vectoring for atan2. Depends on kmf_pkg.
module kmf_cordic (
  input  logic                     clk,
  input  logic                     rst_n,
  input  kmf_pkg::kmf_cordic_req_t req,
  output kmf_pkg::kmf_cordic_rsp_t rsp
);
  import kmf_pkg::*;

  localparam logic signed [33:0] QTURN = 34'sd1073741824;
  localparam logic signed [33:0] HTURN = 34'sd2147483648;
  localparam logic signed [33:0] RND   = 34'sd16384;
  localparam logic signed [33:0] ONE   = 34'sd32768;

  kmf_cordic_state_t  cs_r, cs_nxt;
  logic signed [33:0] x_r, x_nxt, y_r, y_nxt, z_r, z_nxt;
  logic [3:0]         it_r, it_nxt;
  kmf_cordic_mode_t   mode_r, mode_nxt;
  logic               neg_r, neg_nxt;
  logic               done_r, done_nxt;
  logic signed [16:0] cos_r, cos_nxt, sin_r, sin_nxt;

  logic signed [33:0] z0, xv, yv, sx, sy, at, cx, cy;
  logic               cw;

  function automatic logic signed [33:0] rnd15(input logic signed [33:0] v);
    if (v >= 0) return (v + RND) >>> 15;
    else return -((-v + RND) >>> 15);
  endfunction

  function automatic logic signed [16:0] sat17(input logic signed [33:0] v);
    if (v > ONE) return 17'(ONE);
    else if (v < -ONE) return 17'(-ONE);
    else return 17'(v);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cs_r   <= CS_IDLE;
      done_r <= 1'b0;
    end else begin
      cs_r   <= cs_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    z_r    <= z_nxt;
    it_r   <= it_nxt;
    mode_r <= mode_nxt;
    neg_r  <= neg_nxt;
    cos_r  <= cos_nxt;
    sin_r  <= sin_nxt;
  end

  always_comb begin
    cs_nxt   = cs_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    z_nxt    = z_r;
    it_nxt   = it_r;
    mode_nxt = mode_r;
    neg_nxt  = neg_r;
    done_nxt = 1'b0;
    cos_nxt  = cos_r;
    sin_nxt  = sin_r;
    z0 = 34'($signed(req.angle));
    xv = 34'(req.vx) <<< 14;
    yv = 34'(req.vy) <<< 14;
    sx = x_r >>> it_r;
    sy = y_r >>> it_r;
    at = $signed({2'b00, ATAN_TURN[it_r]});
    cw = (mode_r == CM_ROTATE) ? z_r[33] : (y_r > 0);
    cx = rnd15(x_r);
    cy = rnd15(y_r);
    case (cs_r)
      CS_IDLE: begin
        if (req.start) begin
          mode_nxt = req.mode;
          it_nxt   = 4'd0;
          cs_nxt   = CS_ITER;
          if (req.mode == CM_ROTATE) begin
            x_nxt   = 34'(CORDIC_GAIN_INV);
            y_nxt   = 34'sd0;
            neg_nxt = 1'b0;
            z_nxt   = z0;
            // fold into the right half plane
            if (z0 > QTURN) begin
              z_nxt   = z0 - HTURN;
              neg_nxt = 1'b1;
            end else if (z0 < -QTURN) begin
              z_nxt   = z0 + HTURN;
              neg_nxt = 1'b1;
            end
          end else begin
            neg_nxt = 1'b0;
            if (xv < 0) begin
              x_nxt = -xv;
              y_nxt = -yv;
              z_nxt = HTURN;
            end else begin
              x_nxt = xv;
              y_nxt = yv;
              z_nxt = 34'sd0;
            end
          end
        end
      end
      CS_ITER: begin
        if (cw) begin
          x_nxt = x_r + sy;
          y_nxt = y_r - sx;
          z_nxt = z_r + at;
        end else begin
          x_nxt = x_r - sy;
          y_nxt = y_r + sx;
          z_nxt = z_r - at;
        end
        it_nxt = it_r + 4'd1;
        if (it_r == 4'(CORDIC_ITERS - 1)) cs_nxt = CS_FIN;
      end
      CS_FIN: begin
        cos_nxt  = sat17(neg_r ? -cx : cx);
        sin_nxt  = sat17(neg_r ? -cy : cy);
        done_nxt = 1'b1;
        cs_nxt   = CS_IDLE;
      end
      default: cs_nxt = CS_IDLE;
    endcase
  end

  assign rsp.done  = done_r;
  assign rsp.cos_v = cos_r;
  assign rsp.sin_v = sin_r;
  assign rsp.z     = z_r[31:0];

endmodule

// ----- hdl/kmf_div.sv -----
// Restoring divider, one quotient bit per cycle, unsigned.
// Depends on nothing beyond its parameters.
module kmf_div #(
  parameter int NUM_W = 24,
  parameter int DEN_W = 9
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);
  localparam int CW = $clog2(NUM_W);

  logic             busy_r, busy_nxt, done_r, done_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt, den_r, den_nxt;
  logic [NUM_W-1:0] q_r, q_nxt;
  logic [DEN_W:0]   t, diff;
  logic             ge;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    q_r   <= q_nxt;
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    q_nxt    = q_r;
    t    = {rem_r, q_r[NUM_W-1]};
    ge   = t >= {1'b0, den_r};
    diff = t - {1'b0, den_r};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      den_nxt  = den;
      q_nxt    = num;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[DEN_W-1:0] : t[DEN_W-1:0];
      q_nxt   = {q_r[NUM_W-2:0], ge};
      cnt_nxt = cnt_r + CW'(1);
      if (cnt_r == CW'(NUM_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  assign done = done_r;
  assign quo  = q_r;

endmodule

// ----- hdl/kmf_isqrt.sv -----
// Bit-pair integer square root of a 32-bit value, one result bit per cycle.
// No dependencies.
module kmf_isqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] v_in,
  output logic        done,
  output logic [15:0] res
);
  logic        busy_r, busy_nxt, done_r, done_nxt;
  logic [31:0] v_r, v_nxt, res_r, res_nxt, bit_r, bit_nxt, sum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v_r   <= v_nxt;
    res_r <= res_nxt;
    bit_r <= bit_nxt;
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    v_nxt    = v_r;
    res_nxt  = res_r;
    bit_nxt  = bit_r;
    sum      = res_r + bit_r;
    if (start) begin
      busy_nxt = 1'b1;
      v_nxt    = v_in;
      res_nxt  = '0;
      bit_nxt  = 32'h4000_0000;
    end else if (busy_r) begin
      if (v_r >= sum) begin
        v_nxt   = v_r - sum;
        res_nxt = (res_r >> 1) + bit_r;
      end else begin
        res_nxt = res_r >> 1;
      end
      bit_nxt = bit_r >> 2;
      if (bit_r == 32'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  assign done = done_r;
  assign res  = res_r[15:0];

endmodule

// ----- hdl/kuramoto_mean_field_step_top.sv -----
// Oscillator swarm step. A step runs a scatter pass when the seed changes, then a mean pass,
// the divides, the square root, the atan2 (skipped when the mean vector is zero) and an
// update pass; its time is set by the single CORDIC unit at one micro-rotation per cycle,
// used once per entry in the mean and update passes.
// Reset is synchronous: it clears the sequencer, loads the register defaults
// and sets the last seed to all ones; the tables hold nothing until loaded.
`include "kuramoto_mean_field_step_top_defines.svh"
module kuramoto_mean_field_step_top #(
  parameter int MAX_OSCILLATORS = kmf_pkg::MAX_OSC_DEF,
  parameter int PHASE_BITS      = kmf_pkg::PHASE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  kmf_in_if.sink                          in_ch,
  kmf_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [kmf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [kmf_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import kmf_pkg::*;

  localparam int AW        = $clog2(MAX_OSCILLATORS);
  localparam int CNT_W     = $clog2(MAX_OSCILLATORS + 1);
  localparam int SUM_MAG_W = $clog2(MAX_OSCILLATORS) + 16;
  localparam int SUM_W     = SUM_MAG_W + 1;
  localparam int PSHIFT    = 32 - PHASE_BITS;
  localparam logic [31:0] PHALF = 32'd1 << (31 - PHASE_BITS);

  function automatic logic [PHASE_BITS-1:0] to_phase(input logic [31:0] t);
    logic [31:0] s;
    s = t + PHALF;
    return s[31:PSHIFT];
  endfunction

  // tables
  logic [PHASE_BITS-1:0] phase_mem [MAX_OSCILLATORS];
  logic [15:0]           freq_mem  [MAX_OSCILLATORS];
  logic [PHASE_BITS-1:0] ph_rd_r, ph_wd;
  logic [15:0]           fr_rd_r, fr_wd;
  logic                  ph_we, fr_we;
  logic [AW-1:0]         wa, rd_addr;

  kmf_state_t         state_r, state_nxt;
  logic [CNT_W-1:0]   i_r, i_nxt, n_r, n_nxt;
  logic [8:0]         active_count_r, active_count_nxt;
  logic [15:0]        thr_r, thr_nxt;
  logic [31:0]        last_seed_r, last_seed_nxt;
  logic               out_valid_r, out_valid_nxt;

  logic [15:0]        k_r, k_nxt, r_r, r_nxt, order_r, order_nxt, mphase_r, mphase_nxt;
  logic               coh_r, coh_nxt, pneg_r, pneg_nxt;
  logic [31:0]        q_r, q_nxt, sq_r, sq_nxt, psi_r, psi_nxt;
  logic signed [SUM_W-1:0] sx_r, sx_nxt, sy_r, sy_nxt;
  logic signed [16:0] mx_r, mx_nxt, my_r, my_nxt;
  logic [16:0]        kr_r, kr_nxt;
  logic signed [33:0] p1_r, p1_nxt;
  logic [61:0]        p2_r, p2_nxt;

  kmf_cordic_req_t    cordic_req;
  kmf_cordic_rsp_t    cordic_rsp;
  logic               div_start, div_done, sqrt_start, sqrt_done;
  logic [SUM_MAG_W-1:0] div_num, div_quo;
  logic [SUM_W-1:0]   div_abs;
  logic signed [SUM_W-1:0] div_src;
  logic [15:0]        sqrt_res;

  logic               accept, last_i, cordic_wt;
  logic [31:0]        th32, fr32, scat_off, kr_prod, n32, ac32, idx32, d32, p1_mag;
  logic [61:0]        p2_rnd;
  logic signed [16:0] sq_op, q17;
  logic signed [33:0] sq_prod;

  kmf_cordic u_cordic (.clk, .rst_n, .req(cordic_req), .rsp(cordic_rsp));

  kmf_div #(.NUM_W(SUM_MAG_W), .DEN_W(CNT_W)) u_div (
    .clk, .rst_n, .start(div_start), .num(div_num), .den(n_r),
    .done(div_done), .quo(div_quo)
  );

  kmf_isqrt u_isqrt (
    .clk, .rst_n, .start(sqrt_start), .v_in(sq_r), .done(sqrt_done), .res(sqrt_res)
  );

  assign rd_addr = i_r[AW-1:0];

  always_ff @(posedge clk) begin
    if (ph_we) phase_mem[wa] <= ph_wd;
    ph_rd_r <= phase_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (fr_we) freq_mem[wa] <= fr_wd;
    fr_rd_r <= freq_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      i_r            <= '0;
      n_r            <= CNT_W'(1);
      active_count_r <= ACTIVE_COUNT_RST;
      thr_r          <= COH_THRESH_RST;
      last_seed_r    <= LAST_SEED_RST;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      i_r            <= i_nxt;
      n_r            <= n_nxt;
      active_count_r <= active_count_nxt;
      thr_r          <= thr_nxt;
      last_seed_r    <= last_seed_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r      <= k_nxt;
    r_r      <= r_nxt;
    q_r      <= q_nxt;
    sq_r     <= sq_nxt;
    psi_r    <= psi_nxt;
    sx_r     <= sx_nxt;
    sy_r     <= sy_nxt;
    mx_r     <= mx_nxt;
    my_r     <= my_nxt;
    kr_r     <= kr_nxt;
    p1_r     <= p1_nxt;
    p2_r     <= p2_nxt;
    pneg_r   <= pneg_nxt;
    order_r  <= order_nxt;
    mphase_r <= mphase_nxt;
    coh_r    <= coh_nxt;
  end

  assign in_ch.ready            = (state_r == S_IDLE);
  assign accept                 = in_ch.valid && in_ch.ready;
  assign out_ch.valid           = out_valid_r;
  assign out_ch.order_magnitude = order_r;
  assign out_ch.mean_phase      = mphase_r;
  assign out_ch.coherent        = coh_r;
  assign cordic_wt = (state_r == S_SUM_WT || state_r == S_ATAN_W || state_r == S_UP_WT);

  always_comb begin
    ac32     = 32'(active_count_r);
    idx32    = 32'(in_ch.osc_index);
    n32      = (ac32 == 32'd0) ? 32'd1 :
               ((ac32 > 32'(MAX_OSCILLATORS)) ? 32'(MAX_OSCILLATORS) : ac32);
    last_i   = (i_r == n_r - CNT_W'(1));
    th32     = 32'(ph_rd_r) << PSHIFT;
    fr32     = {fr_rd_r, 16'h0000};
    scat_off = 32'(q_r[23:12]) * SCATTER_STEP;
    div_src  = (state_r == S_DIV_X) ? sx_r : sy_r;
    div_abs  = div_src[SUM_W-1] ? -div_src : div_src;
    div_num  = div_abs[SUM_MAG_W-1:0] + SUM_MAG_W'(n_r >> 1);
    q17      = $signed({1'b0, div_quo[15:0]});
    sq_op    = (state_r == S_SQ_X) ? mx_r : my_r;
    sq_prod  = sq_op * sq_op;
    kr_prod  = 32'(k_r) * 32'(r_r) + 32'd16384;
    p1_mag   = p1_r[33] ? 32'(-p1_r) : 32'(p1_r);
    p2_rnd   = p2_r + (62'd1 << 30);
    d32      = pneg_r ? -(32'(p2_rnd[61:31])) : 32'(p2_rnd[61:31]);
  end

  always_comb begin
    state_nxt        = state_r;
    i_nxt            = i_r;
    n_nxt            = n_r;
    active_count_nxt = active_count_r;
    thr_nxt          = thr_r;
    last_seed_nxt    = last_seed_r;
    out_valid_nxt    = out_valid_r && !out_ch.ready;
    k_nxt      = k_r;
    r_nxt      = r_r;
    q_nxt      = q_r;
    sq_nxt     = sq_r;
    psi_nxt    = psi_r;
    sx_nxt     = sx_r;
    sy_nxt     = sy_r;
    mx_nxt     = mx_r;
    my_nxt     = my_r;
    kr_nxt     = kr_r;
    p1_nxt     = p1_r;
    p2_nxt     = p2_r;
    pneg_nxt   = pneg_r;
    order_nxt  = order_r;
    mphase_nxt = mphase_r;
    coh_nxt    = coh_r;
    ph_we = 1'b0;
    fr_we = 1'b0;
    wa    = rd_addr;
    ph_wd = to_phase(th32 + scat_off);
    fr_wd = in_ch.natural_freq;
    cordic_req.start = 1'b0;
    cordic_req.mode  = CM_ROTATE;
    cordic_req.angle = th32;
    cordic_req.vx    = mx_r;
    cordic_req.vy    = my_r;
    div_start  = 1'b0;
    sqrt_start = 1'b0;

    if (cfg_we) begin
      case (cfg_index)
        CFG_ACTIVE_COUNT:  active_count_nxt = cfg_wdata[8:0];
        CFG_COH_THRESHOLD: thr_nxt = cfg_wdata;
        default: ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (!in_ch.kind) begin
            wa    = idx32[AW-1:0];
            ph_wd = to_phase({in_ch.init_phase, 16'h0000});
            ph_we = (idx32 < 32'(MAX_OSCILLATORS));
            fr_we = ph_we;
          end else begin
            k_nxt  = in_ch.coupling;
            n_nxt  = n32[CNT_W-1:0];
            i_nxt  = '0;
            sx_nxt = '0;
            sy_nxt = '0;
            q_nxt  = in_ch.seed | 32'd1;
            last_seed_nxt = in_ch.seed;
            state_nxt = (in_ch.seed != last_seed_r) ? S_SC_RD : S_SUM_RD;
          end
        end
      end
      S_SC_RD: begin
        q_nxt     = xorshift32(q_r);
        state_nxt = S_SC_WR;
      end
      S_SC_WR: begin
        ph_we = 1'b1;
        if (last_i) begin
          i_nxt     = '0;
          state_nxt = S_SUM_RD;
        end else begin
          i_nxt     = i_r + CNT_W'(1);
          state_nxt = S_SC_RD;
        end
      end
      S_SUM_RD: state_nxt = S_SUM_ST;
      S_SUM_ST: begin
        cordic_req.start = 1'b1;
        state_nxt = S_SUM_WT;
      end
      S_SUM_WT: begin
        if (cordic_rsp.done) begin
          sx_nxt = sx_r + SUM_W'(cordic_rsp.cos_v);
          sy_nxt = sy_r + SUM_W'(cordic_rsp.sin_v);
          if (last_i) begin
            i_nxt     = '0;
            state_nxt = S_DIV_X;
          end else begin
            i_nxt     = i_r + CNT_W'(1);
            state_nxt = S_SUM_RD;
          end
        end
      end
      S_DIV_X: begin
        div_start = 1'b1;
        state_nxt = S_DIV_XW;
      end
      S_DIV_XW: begin
        if (div_done) begin
          mx_nxt    = sx_r[SUM_W-1] ? -q17 : q17;
          state_nxt = S_DIV_Y;
        end
      end
      S_DIV_Y: begin
        div_start = 1'b1;
        state_nxt = S_DIV_YW;
      end
      S_DIV_YW: begin
        if (div_done) begin
          my_nxt    = sy_r[SUM_W-1] ? -q17 : q17;
          state_nxt = S_SQ_X;
        end
      end
      S_SQ_X: begin
        sq_nxt    = sq_prod[31:0];
        state_nxt = S_SQ_Y;
      end
      S_SQ_Y: begin
        sq_nxt    = sq_r + sq_prod[31:0];
        state_nxt = S_SQRT;
      end
      S_SQRT: begin
        sqrt_start = 1'b1;
        state_nxt  = S_SQRT_W;
      end
      S_SQRT_W: begin
        if (sqrt_done) begin
          r_nxt     = (sqrt_res > Q15_ONE) ? Q15_ONE : sqrt_res;
          state_nxt = S_ATAN;
        end
      end
      S_ATAN: begin
        // zero mean vector: psi is set to zero
        if (mx_r == 17'sd0 && my_r == 17'sd0) begin
          psi_nxt   = '0;
          state_nxt = S_KR;
        end else begin
          cordic_req.start = 1'b1;
          cordic_req.mode  = CM_VECTOR;
          state_nxt = S_ATAN_W;
        end
      end
      S_ATAN_W: begin
        if (cordic_rsp.done) begin
          psi_nxt   = cordic_rsp.z;
          state_nxt = S_KR;
        end
      end
      S_KR: begin
        kr_nxt    = kr_prod[31:15];
        state_nxt = S_UP_RD;
      end
      S_UP_RD: state_nxt = S_UP_ST;
      S_UP_ST: begin
        cordic_req.start = 1'b1;
        cordic_req.angle = psi_r - th32;
        state_nxt = S_UP_WT;
      end
      S_UP_WT: begin
        if (cordic_rsp.done) begin
          p1_nxt    = 34'($signed({1'b0, kr_r})) * 34'(cordic_rsp.sin_v);
          state_nxt = S_UP_M2;
        end
      end
      S_UP_M2: begin
        p2_nxt    = 62'(p1_mag) * 62'(INV_TWO_PI_Q32);
        pneg_nxt  = p1_r[33];
        state_nxt = S_UP_WR;
      end
      S_UP_WR: begin
        ph_we = 1'b1;
        ph_wd = to_phase(th32 + fr32 + d32);
        if (last_i) begin
          i_nxt     = '0;
          state_nxt = S_DONE;
        end else begin
          i_nxt     = i_r + CNT_W'(1);
          state_nxt = S_UP_RD;
        end
      end
      S_DONE: begin
        // hold until the previous result has been transferred
        if (!out_valid_r || out_ch.ready) begin
          order_nxt     = r_r;
          mphase_nxt    = 16'((psi_r + 32'h0000_8000) >> 16);
          coh_nxt       = (r_r > thr_r);
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  `KMF_ASSERT(a_cordic_done_waited, cordic_rsp.done |-> cordic_wt)
  `KMF_ASSERT(a_div_done_waited, div_done |-> (state_r == S_DIV_XW || state_r == S_DIV_YW))
  `KMF_ASSERT(a_index_in_range, (state_r != S_IDLE) |-> (i_r < n_r))
  `KMF_ASSERT(a_result_held, out_valid_r && !out_ch.ready |=> out_valid_r && $stable(order_r))

endmodule
